FILE: design/vmp_pkg.sv
// ---------------------------------------------------------------------------
// vmp_pkg
// Shared constants and types for the integer vector-matrix product core.
// ---------------------------------------------------------------------------
package vmp_pkg;

    localparam int MAX_DIM   = 16;
    localparam int ELEM_BITS = 32;

    localparam int DIM_W   = $clog2(MAX_DIM);
    localparam int CNT_W   = $clog2(MAX_DIM + 1);
    localparam int ADDR_W  = $clog2(MAX_DIM * MAX_DIM);
    localparam int PROD_W  = 2 * ELEM_BITS;
    localparam int ACC_W   = 64;

    localparam int SIZE_W     = 5;
    localparam int SIZE_RESET = 16;

    localparam int IDX_W   = 4;
    localparam int VALUE_W = 32;

    localparam logic KIND_MATRIX = 1'b0;
    localparam logic KIND_VECTOR = 1'b1;

    localparam int REG_SIZE_IN_USE = 0;

    typedef struct packed {
        logic             valid;
        logic             clear;
        logic [DIM_W-1:0] idx;
    } mac_ctl_t;

endpackage

FILE: design/vmp_mem.sv
// ---------------------------------------------------------------------------
// vmp_mem
// Matrix store: one write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module vmp_mem
    import vmp_pkg::*;
(
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_W-1:0]    waddr,
    input  logic [ELEM_BITS-1:0] wdata,
    input  logic                 re,
    input  logic [ADDR_W-1:0]    raddr,
    output logic [ELEM_BITS-1:0] rdata
);

    logic [ELEM_BITS-1:0] mem [MAX_DIM*MAX_DIM];
    logic [ELEM_BITS-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/vmp_mac.sv
// ---------------------------------------------------------------------------
// vmp_mac
// Shared multiply-accumulate unit: registered product, then add into the
// selected accumulator. Holds the accumulator bank.
// ---------------------------------------------------------------------------
module vmp_mac
    import vmp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  mac_ctl_t             ctl,
    input  logic [ELEM_BITS-1:0] vec_val,
    input  logic [ELEM_BITS-1:0] mat_val,
    input  logic [DIM_W-1:0]     rd_idx,
    output logic [ACC_W-1:0]     rd_data,
    output logic                 busy
);

    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     prod_valid_reg;
    logic [DIM_W-1:0]         prod_idx_reg;
    logic [ACC_W-1:0]         acc_reg [MAX_DIM];

    assign prod_next = $signed(vec_val) * $signed(mat_val);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.valid)
        begin
            prod_reg     <= prod_next;
            prod_idx_reg <= ctl.idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_DIM; k++)
            begin
                acc_reg[k] <= '0;
            end
        end
        else if (ctl.clear)
        begin
            for (int k = 0; k < MAX_DIM; k++)
            begin
                acc_reg[k] <= '0;
            end
        end
        else if (prod_valid_reg)
        begin
            acc_reg[prod_idx_reg] <= acc_reg[prod_idx_reg] + ACC_W'(prod_reg);
        end
    end

    assign rd_data = acc_reg[rd_idx];
    assign busy    = prod_valid_reg;

endmodule

FILE: design/integer_vector_matrix_product_core.sv
// ---------------------------------------------------------------------------
// integer_vector_matrix_product_core
// Row vector times stored square matrix, 64-bit wrapping sums.
// ---------------------------------------------------------------------------
// A kind-0 beat writes one matrix entry. A kind-1 beat whose index j is below
// n reads row j of the matrix one entry per cycle and feeds one shared
// multiply-accumulate unit. in_ready then stays low while the n reads are
// issued, the read data and the product are registered, and the last
// accumulate lands. A kind-1 beat with last set then emits n result beats,
// one per cycle while out_ready stays high, and clears the accumulators.
// in_ready is low while an item is in progress.
// n comes from size_in_use (0 acts as 1, above 16 acts as 16) at APB
// address 0. The matrix must be written before it is used.
// ---------------------------------------------------------------------------
module integer_vector_matrix_product_core
    import vmp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               kind,
    input  logic [IDX_W-1:0]   row_index,
    input  logic [IDX_W-1:0]   col_index,
    input  logic [VALUE_W-1:0] value,
    input  logic               last,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [IDX_W-1:0]   result_index,
    output logic [ACC_W-1:0]   result_value,
    output logic               result_last
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MAC  = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]           state_reg, state_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [SIZE_W-1:0]    size_reg;
    logic [IDX_W-1:0]     row_reg;
    logic [ELEM_BITS-1:0] val_reg;
    logic                 last_reg;
    logic                 rd_valid_reg;
    logic [DIM_W-1:0]     rd_idx_reg;
    logic                 out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]     result_index_reg;
    logic [ACC_W-1:0]     result_value_reg;
    logic                 result_last_reg;

    logic [CNT_W-1:0]     dim;
    logic                 in_fire;
    logic                 cfg_wr;
    logic                 row_ok;
    logic                 mat_we;
    logic [ADDR_W-1:0]    mat_waddr;
    logic                 issue;
    logic [ADDR_W-1:0]    mat_raddr;
    logic [ELEM_BITS-1:0] mat_rdata;
    logic                 emit_load;
    logic                 emit_final;
    logic [ACC_W-1:0]     acc_rd;
    logic                 mac_busy;
    mac_ctl_t             mac_ctl;

    // apb
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'(REG_SIZE_IN_USE));
    assign prdata = (paddr[2] == 1'(REG_SIZE_IN_USE)) ? 32'(size_reg) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= SIZE_W'(SIZE_RESET);
        end
        else if (cfg_wr)
        begin
            size_reg <= pwdata[SIZE_W-1:0];
        end
    end

    always_comb
    begin
        if (size_reg == '0)
        begin
            dim = CNT_W'(1);
        end
        else if (32'(size_reg) > 32'(MAX_DIM))
        begin
            dim = CNT_W'(MAX_DIM);
        end
        else
        begin
            dim = CNT_W'(size_reg);
        end
    end

    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign row_ok   = 32'(row_index) < 32'(dim);

    assign mat_we    = in_fire && (kind == KIND_MATRIX) && (32'(row_index) < 32'(MAX_DIM))
                       && (32'(col_index) < 32'(MAX_DIM));
    assign mat_waddr = ADDR_W'(32'(row_index) * MAX_DIM + 32'(col_index));

    assign issue     = (state_reg == ST_MAC) && (cnt_reg < dim);
    assign mat_raddr = ADDR_W'(32'(row_reg) * MAX_DIM + 32'(cnt_reg));

    assign emit_load  = (state_reg == ST_EMIT) && (!out_valid_reg || out_ready);
    assign emit_final = emit_load && (cnt_reg == dim - CNT_W'(1));

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (in_fire && (kind == KIND_VECTOR))
                begin
                    if (row_ok)
                    begin
                        state_next = ST_MAC;
                    end
                    else if (last)
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_MAC:
            begin
                if (issue)
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                else if (!rd_valid_reg && !mac_busy)
                begin
                    cnt_next   = '0;
                    state_next = last_reg ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (emit_load)
                begin
                    out_valid_next = 1'b1;
                    cnt_next       = cnt_reg + CNT_W'(1);
                    if (emit_final)
                    begin
                        cnt_next   = '0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rd_valid_reg  <= issue;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            row_reg  <= row_index;
            val_reg  <= value[ELEM_BITS-1:0];
            last_reg <= last;
        end
        if (issue)
        begin
            rd_idx_reg <= cnt_reg[DIM_W-1:0];
        end
        if (emit_load)
        begin
            result_index_reg <= IDX_W'(cnt_reg);
            result_value_reg <= acc_rd;
            result_last_reg  <= emit_final;
        end
    end

    assign mac_ctl.valid = rd_valid_reg;
    assign mac_ctl.clear = emit_final;
    assign mac_ctl.idx   = rd_idx_reg;

    vmp_mem u_mem
    (
        .clk   (clk),
        .we    (mat_we),
        .waddr (mat_waddr),
        .wdata (value[ELEM_BITS-1:0]),
        .re    (issue),
        .raddr (mat_raddr),
        .rdata (mat_rdata)
    );

    vmp_mac u_mac
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (mac_ctl),
        .vec_val (val_reg),
        .mat_val (mat_rdata),
        .rd_idx  (cnt_reg[DIM_W-1:0]),
        .rd_data (acc_rd),
        .busy    (mac_busy)
    );

    assign out_valid    = out_valid_reg;
    assign result_index = result_index_reg;
    assign result_value = result_value_reg;
    assign result_last  = result_last_reg;

    a_rd_in_mac: assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> (state_reg == ST_MAC))
        else $error("matrix read outside MAC phase");

    a_emit_idle_mac: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (!mac_busy && !rd_valid_reg))
        else $error("accumulate pending during emission");

    a_emit_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (cnt_reg < dim))
        else $error("emission index beyond dimension");

    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_EMIT))
        else $error("result beat raised outside emission");

endmodule
